// ----- rtl/tlpq_pkg.sv -----
`timescale 1ns / 1ps

package tlpq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP_PRIO = 2'd1,
    OP_POP_URG  = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned TOTAL_W     = 6;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// ----- rtl/tlpq_fifo.sv -----
`timescale 1ns / 1ps

module tlpq_fifo #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlpq_pkg::fifo_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0]           wr_data,
  input  logic [tlpq_pkg::LIMIT_W-1:0]   limit,
  output logic                           can_push,
  output logic [CNT_W-1:0]               count,
  output logic [WORD_BITS-1:0]           rd_data
);

  localparam int unsigned LW = (CNT_W > tlpq_pkg::LIMIT_W) ? CNT_W : tlpq_pkg::LIMIT_W;

  logic [WORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [WORD_BITS-1:0] rd_data_r;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign can_push = (LW'(count_r) < LW'(limit)) && (LW'(count_r) < LW'(QUEUE_DEPTH));
  assign count    = count_r;
  assign rd_data  = rd_data_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (ctrl.push) begin
      tail_nxt  = advance(tail_r);
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      head_nxt  = advance(head_r);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      mem[tail_r] <= wr_data;
    end
    if (ctrl.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

// ----- rtl/two_level_priority_command_queue_unit.sv -----
`timescale 1ns / 1ps
// Two-level command queue: an urgent queue served ahead of a regular queue.
// Input words: in_tdata carries the command word, in_tuser the opcode and the
// push target. Opcodes: push, pop by priority, pop urgent only, clear both.
// Every input word yields exactly one output word on out_tdata with the push
// status, pop status, popped command, total occupancy and an all-empty flag.
// For each operation, the accept cycle updates pointers and counts and issues
// the write or the read of the queue memory; the next cycle picks up the
// registered read data and loads the output register. No new word is accepted
// while an operation is in flight.
// The output register holds its word while out_tready is low; a new input word
// is accepted only once that register is free or being drained.
// cfg_data sets the per-queue limit (reset 16, values above the depth act as
// the depth); write it only while the block is idle. cfg_ready is always high.
// Reset (rst_n low, synchronous) empties both queues and sets the limit to 16;
// memory contents are not cleared, no entry is read before it is written.
module two_level_priority_command_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,  // [31:0] command_word
  input  logic [2:0]                         in_tuser,  // [1:0] opcode, [2] is_immediate
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] push_accepted, [1] pop_valid, [33:2] popped_command,
  // [39:34] total_count, [40] all_empty, [47:41] zero
  output logic [tlpq_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlpq_pkg::LIMIT_W-1:0]       cfg_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 7;

  tlpq_pkg::state_t  state_r, state_nxt;
  tlpq_pkg::opcode_t opcode;
  logic              is_imm;
  logic              in_acc;
  logic              load_out;

  logic [tlpq_pkg::LIMIT_W-1:0] max_entries_r;

  tlpq_pkg::fifo_ctrl_t urg_ctrl, reg_ctrl;
  logic                 urg_can_push, reg_can_push;
  logic [CNT_W-1:0]     urg_cnt, reg_cnt;
  logic [WORD_BITS-1:0] urg_rd, reg_rd, wr_word;
  logic [WORD_BITS+31:0] wr_ext;

  logic acc_r, pop_urg_r, pop_reg_r;
  logic push_ok, pop_urg, pop_reg;

  logic [WORD_BITS-1:0]  pop_word;
  logic [WORD_BITS+31:0] pop_ext;
  logic [SUM_W-1:0]      sum;
  logic [tlpq_pkg::TOTAL_W-1:0] total;

  logic                           out_valid_r;
  logic [tlpq_pkg::OUT_DATA_W-1:0] out_data_r;

  assign opcode = tlpq_pkg::opcode_t'(in_tuser[1:0]);
  assign is_imm = in_tuser[2];

  assign wr_ext  = {{WORD_BITS{1'b0}}, in_tdata};
  assign wr_word = wr_ext[WORD_BITS-1:0];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= tlpq_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      max_entries_r <= cfg_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlpq_pkg::S_IDLE: if (in_acc) state_nxt = tlpq_pkg::S_READ;
      tlpq_pkg::S_READ: state_nxt = tlpq_pkg::S_IDLE;
      default:          state_nxt = tlpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      tlpq_pkg::S_IDLE: in_tready = !out_valid_r || out_tready;
      tlpq_pkg::S_READ: load_out  = 1'b1;
      default: begin
        in_tready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    push_ok = 1'b0;
    pop_urg = 1'b0;
    pop_reg = 1'b0;
    unique case (opcode)
      tlpq_pkg::OP_PUSH:     push_ok = is_imm ? urg_can_push : reg_can_push;
      tlpq_pkg::OP_POP_PRIO: begin
        pop_urg = (urg_cnt != '0);
        pop_reg = (urg_cnt == '0) && (reg_cnt != '0);
      end
      tlpq_pkg::OP_POP_URG:  pop_urg = (urg_cnt != '0);
      default: begin
        push_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    urg_ctrl.push  = in_acc && push_ok && is_imm;
    urg_ctrl.pop   = in_acc && pop_urg;
    urg_ctrl.clear = in_acc && (opcode == tlpq_pkg::OP_CLEAR);
    reg_ctrl.push  = in_acc && push_ok && !is_imm;
    reg_ctrl.pop   = in_acc && pop_reg;
    reg_ctrl.clear = in_acc && (opcode == tlpq_pkg::OP_CLEAR);
  end

  tlpq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_urg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (urg_ctrl),
    .wr_data  (wr_word),
    .limit    (max_entries_r),
    .can_push (urg_can_push),
    .count    (urg_cnt),
    .rd_data  (urg_rd)
  );

  tlpq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (reg_ctrl),
    .wr_data  (wr_word),
    .limit    (max_entries_r),
    .can_push (reg_can_push),
    .count    (reg_cnt),
    .rd_data  (reg_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r     <= push_ok;
      pop_urg_r <= pop_urg;
      pop_reg_r <= pop_reg;
    end
  end

  always_comb begin
    pop_word = '0;
    if (pop_urg_r) begin
      pop_word = urg_rd;
    end else if (pop_reg_r) begin
      pop_word = reg_rd;
    end
  end

  assign pop_ext = {32'b0, pop_word};
  assign sum     = SUM_W'(urg_cnt) + SUM_W'(reg_cnt);
  assign total   = (sum > SUM_W'(63)) ? tlpq_pkg::TOTAL_W'(63) : sum[tlpq_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {7'b0, (sum == '0), total, pop_ext[31:0],
                     (pop_urg_r || pop_reg_r), acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == tlpq_pkg::S_IDLE))
    else $error("input taken while an operation is in flight");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##1 out_tvalid)
    else $error("accepted word produced no output");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(QUEUE_DEPTH) >= urg_cnt) && (CNT_W'(QUEUE_DEPTH) >= reg_cnt))
    else $error("queue count exceeds depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("push and pop reported together");
`endif

endmodule

// ----- sim/two_level_priority_command_queue_unit_tb.sv -----
`timescale 1ns / 1ps

module two_level_priority_command_queue_unit_tb;

  localparam int unsigned DEPTH = 16;

  typedef struct {
    tlpq_pkg::opcode_t opcode;
    logic              urgent;
    logic [31:0]       word;
  } queue_op_t;

  typedef struct packed {
    logic        push_ok;
    logic        pop_ok;
    logic [31:0] cmd;
    logic [5:0]  total;
    logic        empty;
  } queue_reply_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;   // [31:0] command_word
  logic [2:0]                      in_tuser;   // [1:0] opcode, [2] is_immediate
  logic                            out_tvalid;
  logic                            out_tready;
  logic [tlpq_pkg::OUT_DATA_W-1:0] out_tdata;  // [0] push_accepted, [1] pop_valid,
                                               // [33:2] popped_command,
                                               // [39:34] total_count, [40] all_empty
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tlpq_pkg::LIMIT_W-1:0]    cfg_data;

  queue_op_t    op_backlog[$];
  queue_reply_t predicted_replies[$];
  logic [31:0]  urgent_cmds[$];
  logic [31:0]  regular_cmds[$];
  int unsigned  limit_now;
  int unsigned  ops_issued;
  int unsigned  replies_seen;
  int unsigned  errors;

  queue_op_t    drv_op;
  int unsigned  burst_left;
  int unsigned  gap_left;
  logic [7:0]   ready_pat;
  int unsigned  pat_age;
  queue_reply_t got_reply;
  queue_reply_t want_reply;

  two_level_priority_command_queue_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_reply_t apply_queue_op(queue_op_t op);
    queue_reply_t r;
    int unsigned  cap;
    r = '0;
    cap = (limit_now > DEPTH) ? DEPTH : limit_now;
    case (op.opcode)
      tlpq_pkg::OP_PUSH: begin
        if (op.urgent) begin
          if (urgent_cmds.size() < cap) begin
            urgent_cmds.insert(urgent_cmds.size(), op.word);
            r.push_ok = 1'b1;
          end
        end else if (regular_cmds.size() < cap) begin
          regular_cmds.insert(regular_cmds.size(), op.word);
          r.push_ok = 1'b1;
        end
      end
      tlpq_pkg::OP_POP_PRIO: begin
        if (urgent_cmds.size() != 0) begin
          r.pop_ok = 1'b1;
          r.cmd = urgent_cmds[0];
          urgent_cmds.delete(0);
        end else if (regular_cmds.size() != 0) begin
          r.pop_ok = 1'b1;
          r.cmd = regular_cmds[0];
          regular_cmds.delete(0);
        end
      end
      tlpq_pkg::OP_POP_URG: begin
        if (urgent_cmds.size() != 0) begin
          r.pop_ok = 1'b1;
          r.cmd = urgent_cmds[0];
          urgent_cmds.delete(0);
        end
      end
      default: begin
        urgent_cmds.delete();
        regular_cmds.delete();
      end
    endcase
    r.total = 6'(urgent_cmds.size() + regular_cmds.size());
    r.empty = (r.total == 6'd0);
    return r;
  endfunction

  task automatic add_op(tlpq_pkg::opcode_t opcode, logic urgent, logic [31:0] word);
    queue_op_t op;
    op.opcode = opcode;
    op.urgent = urgent;
    op.word = word;
    op_backlog.insert(op_backlog.size(), op);
    ops_issued++;
  endtask

  task automatic add_random_ops(int unsigned n, int unsigned push_pct);
    int unsigned       roll;
    logic [31:0]       word;
    tlpq_pkg::opcode_t opcode;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) opcode = tlpq_pkg::OP_PUSH;
      else if (roll < 97) opcode = $urandom_range(0, 1) ? tlpq_pkg::OP_POP_PRIO
                                                         : tlpq_pkg::OP_POP_URG;
      else opcode = tlpq_pkg::OP_CLEAR;
      case ($urandom_range(0, 9))
        0: word = 32'h0000_0000;
        1: word = 32'hffff_ffff;
        default: word = $urandom;
      endcase
      add_op(opcode, 1'($urandom_range(0, 1)), word);
    end
  endtask

  // hold until every issued word has its reply
  task automatic wait_drained();
    do @(posedge clk); while (replies_seen < ops_issued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [tlpq_pkg::LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_replies.insert(predicted_replies.size(), apply_queue_op(drv_op));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || op_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          drv_op = op_backlog[0];
          op_backlog.delete(0);
          in_tvalid <= 1'b1;
          in_tdata <= drv_op.word;
          in_tuser <= {drv_op.urgent, drv_op.opcode};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern, renewed now and then
  always @(posedge clk) begin
    if (pat_age == 0) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
      pat_age = $urandom_range(8, 80);
    end else begin
      pat_age--;
    end
    ready_pat = {ready_pat[0], ready_pat[7:1]};
    out_tready <= ready_pat[0];
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      got_reply = {out_tdata[0], out_tdata[1], out_tdata[33:2], out_tdata[39:34],
                   out_tdata[40]};
      if (predicted_replies.size() == 0) begin
        errors++;
        $display("%0t: output word expected none actual %h", $time, out_tdata);
      end else begin
        want_reply = predicted_replies[0];
        predicted_replies.delete(0);
        check_field("push_accepted", 32'(want_reply.push_ok), 32'(got_reply.push_ok));
        check_field("pop_valid", 32'(want_reply.pop_ok), 32'(got_reply.pop_ok));
        check_field("popped_command", want_reply.cmd, got_reply.cmd);
        check_field("total_count", 32'(want_reply.total), 32'(got_reply.total));
        check_field("all_empty", 32'(want_reply.empty), 32'(got_reply.empty));
      end
    end
  end

  initial begin
    #2ms;
    $display("two_level_priority_command_queue_unit_tb: errors");
    $finish;
  end

  initial begin
    int unsigned limits[8];
    int unsigned push_pcts[8];
    limits = '{31, 0, 1, 16, 17, 5, 2, 16};
    push_pcts = '{80, 50, 60, 70, 85, 60, 50, 40};
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    limit_now = 16;
    burst_left = 1;
    gap_left = 0;
    pat_age = 0;
    ops_issued = 0;
    replies_seen = 0;
    errors = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_limit(5'd16);
    // empty pops, ordering, stored zero word, clear
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b1, 32'hdead_beef);
    add_op(tlpq_pkg::OP_POP_URG, 1'b0, 32'hffff_ffff);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'hffff_ffff);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h0000_0000);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h5a5a_a5a5);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'h0000_0001);
    add_op(tlpq_pkg::OP_POP_URG, 1'b0, 32'h0);
    add_op(tlpq_pkg::OP_POP_URG, 1'b1, 32'h0);
    add_op(tlpq_pkg::OP_POP_URG, 1'b0, 32'h0);
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b0, 32'h0);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'h8000_0000);
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b0, 32'h0);
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b1, 32'h0);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'ha5a5_5a5a);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'h1234_5678);
    add_op(tlpq_pkg::OP_CLEAR, 1'b1, 32'hffff_ffff);
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b0, 32'h0);
    for (int unsigned i = 0; i < 6; i++) add_op(tlpq_pkg::OP_PUSH, 1'b1, $urandom);
    wait_drained();

    // lower the limit below the urgent occupancy
    write_limit(5'd2);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'h7777_0000);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h0000_7777);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h0000_8888);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h0000_9999);
    add_op(tlpq_pkg::OP_POP_URG, 1'b0, 32'h0);
    wait_drained();

    write_limit(5'd0);
    add_op(tlpq_pkg::OP_PUSH, 1'b1, 32'h1111_1111);
    add_op(tlpq_pkg::OP_PUSH, 1'b0, 32'h2222_2222);
    add_op(tlpq_pkg::OP_POP_PRIO, 1'b0, 32'h0);
    add_op(tlpq_pkg::OP_CLEAR, 1'b0, 32'h0);
    wait_drained();

    foreach (limits[i]) begin
      write_limit(tlpq_pkg::LIMIT_W'(limits[i]));
      add_random_ops(50, push_pcts[i]);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && predicted_replies.size() == 0) begin
      $display("two_level_priority_command_queue_unit_tb: clean");
    end else begin
      $display("two_level_priority_command_queue_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tlpq_pkg.sv
rtl/tlpq_fifo.sv
rtl/two_level_priority_command_queue_unit.sv
sim/two_level_priority_command_queue_unit_tb.sv
